### rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/fpfs_pkg.sv
`default_nettype none

package fpfs_pkg;

   localparam int ReqDataWidth = 48;
   localparam int RspDataWidth = 104;

   localparam logic [7:0]  MaxLen    = 8'd223;
   localparam logic [7:0]  Pdu2Start = 8'd240;
   localparam logic [7:0]  PadByte   = 8'hFF;
   localparam logic [63:0] AllPad    = {8{PadByte}};
   localparam logic [2:0]  SlotFirstFrame = 3'd2;
   localparam logic [2:0]  SlotNextFrame  = 3'd1;
   localparam logic [2:0]  SlotLast       = 3'd7;

   // last field in the lowest bits
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [7:0]  message_length;
      logic [2:0]  sequence_req;
      logic [7:0]  destination;
      logic [17:0] pgn;
      logic [2:0]  priority_req;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

   typedef struct packed {
      logic [5:0]  zero_fill;
      logic [4:0]  frame_index;
      logic [63:0] frame_data;
      logic [28:0] can_id;
   } rsp_item_type;

   function automatic logic [28:0] build_id(input logic [2:0]  prio,
                                           input logic [17:0] pgn,
                                           input logic [7:0]  src,
                                           input logic [7:0]  dst);
      logic [7:0] pf;
      logic [7:0] ps;
      pf = pgn[15:8];
      ps = (pf < Pdu2Start) ? dst : pgn[7:0];
      return {prio, pgn[17:16], pf, ps, src};
   endfunction

   function automatic logic [63:0] put_byte(input logic [63:0] f,
                                            input logic [2:0]  slot,
                                            input logic [7:0]  v);
      logic [63:0] r;
      r = f;
      r[{slot, 3'b000} +: 8] = v;
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/fast_packet_frame_segmenter.sv
// Channel | Direction | Handshake              | Payload
// req     | in        | req_tvalid/req_tready  | req_tdata: header fields and one payload byte
// rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata: one CAN frame, rsp_tlast = last frame
// csr     | in        | csr_valid/csr_ready    | csr_data: source address
//
// One payload byte is taken every cycle while the result side does not stall; the byte
// that completes a frame passes the input register, then the result register.
// Reset is synchronous; it clears the message counters and both valid flags and
// sets the source address to zero.
// A stalled result holds only bytes that complete a frame; other bytes keep flowing.
`default_nettype none

module fast_packet_frame_segmenter (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // priority_req[2:0], pgn[20:3], destination[28:21], sequence_req[31:29],
   // message_length[39:32], payload_byte[47:40]
   input  wire logic [fpfs_pkg::ReqDataWidth-1:0]  req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // can_id[28:0], frame_data[92:29], frame_index[97:93], zeros[103:98]
   output logic [fpfs_pkg::RspDataWidth-1:0]       rsp_tdata,
   output logic                                    rsp_tlast,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [7:0]                         csr_data
);

   logic [7:0]          source_ff, source_in;
   logic                advance;
   fpfs_pkg::stage_type stage;

   assign csr_ready = 1'b1;
   assign source_in = (csr_valid && csr_ready) ? csr_data : source_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff <= 8'd0;
      end else begin
         source_ff <= source_in;
      end
   end

   fpfs_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .stage      (stage)
   );

   fpfs_pack u_pack (
      .clock          (clock),
      .reset          (reset),
      .stage          (stage),
      .source_address (source_ff),
      .advance        (advance),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast)
   );

endmodule

`default_nettype wire

### rtl/fpfs_in_stage.sv
`default_nettype none

module fpfs_in_stage (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [fpfs_pkg::ReqDataWidth-1:0] req_tdata,
   input  wire logic                             advance,
   output fpfs_pkg::stage_type                   stage
);

   logic                   valid_ff, valid_in;
   fpfs_pkg::req_item_type item_ff, item_in;
   logic                   take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      item_in  = take ? fpfs_pkg::req_item_type'(req_tdata) : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage = {valid_ff, item_ff};

endmodule

`default_nettype wire

### rtl/fpfs_pack.sv
`default_nettype none

`include "assert_macros.svh"

module fpfs_pack (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire fpfs_pkg::stage_type                stage,
   input  wire logic [7:0]                         source_address,
   output logic                                    advance,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [fpfs_pkg::RspDataWidth-1:0]       rsp_tdata,
   output logic                                    rsp_tlast
);

   // message state
   logic [7:0]  taken_ff, taken_in;
   logic [4:0]  count_ff, count_in;
   logic [2:0]  slot_ff, slot_in;
   logic [63:0] frame_ff, frame_in;
   logic [28:0] id_ff, id_in;
   logic [2:0]  seq_ff, seq_in;
   logic [7:0]  len_ff, len_in;

   // result register
   logic                   out_valid_ff, out_valid_in;
   fpfs_pkg::rsp_item_type out_ff, out_in;
   logic                   out_last_ff, out_last_in;

   logic        first;
   logic [7:0]  len_sat;
   logic [28:0] id_cur;
   logic [2:0]  seq_cur;
   logic [7:0]  len_cur;
   logic [4:0]  count_cur;
   logic [2:0]  slot_cur;
   logic [63:0] base_cur;
   logic [63:0] frame_new;
   logic [7:0]  taken_inc;
   logic [4:0]  count_inc;
   logic        last;
   logic        emit;

   // assertion terms
   logic        busy;
   logic        closed;
   logic        stall_emit;

   always_comb begin
      first = (taken_ff == 8'd0);
      if (stage.item.message_length > fpfs_pkg::MaxLen) begin
         len_sat = fpfs_pkg::MaxLen;
      end else if (stage.item.message_length == 8'd0) begin
         len_sat = 8'd1;
      end else begin
         len_sat = stage.item.message_length;
      end

      if (first) begin
         id_cur    = fpfs_pkg::build_id(stage.item.priority_req, stage.item.pgn,
                                        source_address, stage.item.destination);
         seq_cur   = stage.item.sequence_req;
         len_cur   = len_sat;
         count_cur = 5'd0;
         slot_cur  = fpfs_pkg::SlotFirstFrame;
         base_cur  = {{6{fpfs_pkg::PadByte}}, len_sat, stage.item.sequence_req, 5'd0};
      end else begin
         id_cur    = id_ff;
         seq_cur   = seq_ff;
         len_cur   = len_ff;
         count_cur = count_ff;
         slot_cur  = slot_ff;
         base_cur  = frame_ff;
      end

      frame_new = fpfs_pkg::put_byte(base_cur, slot_cur, stage.item.payload_byte);
      taken_inc = taken_ff + 8'd1;
      count_inc = count_cur + 5'd1;
      last      = (taken_inc >= len_cur);
      emit      = (slot_cur == fpfs_pkg::SlotLast) || last;
      // a byte that closes no frame never waits on the result side
      advance   = stage.valid && (!emit || !out_valid_ff || rsp_tready);
   end

   always_comb begin
      taken_in = taken_ff;
      count_in = count_ff;
      slot_in  = slot_ff;
      frame_in = frame_ff;
      id_in    = id_ff;
      seq_in   = seq_ff;
      len_in   = len_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      out_valid_in = rsp_tready ? 1'b0 : out_valid_ff;

      if (advance) begin
         id_in  = id_cur;
         seq_in = seq_cur;
         len_in = len_cur;
         if (!emit) begin
            taken_in = taken_inc;
            count_in = count_cur;
            slot_in  = slot_cur + 3'd1;
            frame_in = frame_new;
         end else begin
            out_valid_in          = 1'b1;
            out_in.zero_fill      = '0;
            out_in.frame_index    = count_cur;
            out_in.frame_data     = frame_new;
            out_in.can_id         = id_cur;
            out_last_in           = last;
            if (last) begin
               taken_in = 8'd0;
               count_in = 5'd0;
               slot_in  = fpfs_pkg::SlotFirstFrame;
               frame_in = fpfs_pkg::AllPad;
            end else begin
               taken_in = taken_inc;
               count_in = count_inc;
               slot_in  = fpfs_pkg::SlotNextFrame;
               frame_in = fpfs_pkg::put_byte(fpfs_pkg::AllPad, 3'd0, {seq_cur, count_inc});
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff     <= 8'd0;
         count_ff     <= 5'd0;
         slot_ff      <= fpfs_pkg::SlotFirstFrame;
         out_valid_ff <= 1'b0;
      end else begin
         taken_ff     <= taken_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
      frame_ff    <= frame_in;
      id_ff       <= id_in;
      seq_ff      <= seq_in;
      len_ff      <= len_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = out_last_ff;

   assign busy       = (taken_ff != 8'd0);
   assign closed     = (taken_ff == 8'd0) && out_valid_ff && out_last_ff;
   assign stall_emit = out_valid_ff && !rsp_tready && stage.valid && emit;

   `ASSERT_IMPL(a_slot_nonzero, clock, reset, busy, slot_ff != 3'd0, "slot zero mid-message")
   `ASSERT_IMPL(a_taken_below_len, clock, reset, busy, taken_ff < len_ff, "count past length")
   `ASSERT_NEXT(a_last_idles, clock, reset, advance && last, closed, "message end not registered")
   `ASSERT_IMPL(a_no_overwrite, clock, reset, stall_emit, !advance, "result overwritten")

endmodule

`default_nettype wire
